### rtl/core/ipv6_neighbor_solicit_responder_assert.svh
// assertion macros shared by the checker
`ifndef IPV6_NEIGHBOR_SOLICIT_RESPONDER_ASSERT_SVH
`define IPV6_NEIGHBOR_SOLICIT_RESPONDER_ASSERT_SVH

// checked only while out of reset
`define NSR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in and out of reset
`define NSR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/nsr_pkg.sv
package nsr_pkg;

    localparam int LEN_WIDTH = 16;
    localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam int WORD_COUNT = 11;
    localparam int WCNT_W = $clog2(WORD_COUNT);

    localparam logic [1:0] KIND_IGNORE = 2'd0;
    localparam logic [1:0] KIND_PASS   = 2'd1;
    localparam logic [1:0] KIND_ADV    = 2'd2;

    localparam logic [1:0] REG_ADDR_HIGH = 2'd0;
    localparam logic [1:0] REG_ADDR_LOW  = 2'd1;
    localparam logic [1:0] REG_CHECK_EN  = 2'd2;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0]  ICMP_NS = 8'd135;
    localparam logic [7:0]  ICMP_NA = 8'd136;
    localparam logic [15:0] ADV_LENGTH = 16'd86;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [15:0] pass_length;
        logic [63:0] reply_word;
        logic [3:0]  reply_bytes;
        logic        run_last;
    } out_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] length;
        logic [47:0] mac;
        logic [63:0] ip_hi;
        logic [63:0] ip_lo;
        logic [63:0] tgt_hi;
        logic [63:0] tgt_lo;
    } desc_t;

    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

endpackage

### rtl/core/ipv6_neighbor_solicit_responder.sv
// ipv6 neighbor solicitation responder
// input channel: one frame byte per beat on in_data, frame_end marks the last byte.
// in_stall rises only when the four-entry frame queue is full; otherwise a byte is
// taken every cycle, so frames stream at one byte per clock.
// output channel: one beat per ignored or passed frame (reply_bytes 0, run_last 1),
// eleven beats of 64-bit words for an advertisement (last one with 6 valid bytes).
// result path: a frame's result passes the queue slot and the output register;
// an advertisement first loads cur_reg, then one word per cycle while not stalled.
// throughput: one result beat per cycle while out_stall is low; an advertisement
// holds the output for its eleven words, set by the single word sequencer in nsr_reply.
// configuration: write own address and check enable through cfg_we/cfg_index/
// cfg_data while idle; unknown indexes are dropped.
// reset: clears capture state, the queue and the output valid; registers read 0.
// when out_stall is high the output beat holds and the queue absorbs up to four
// more frames before input is stalled.
module ipv6_neighbor_solicit_responder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  nsr_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output nsr_pkg::out_t  out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data
);

    nsr_pkg::desc_t push_desc, head_desc;
    nsr_pkg::qctl_t qctl;
    logic q_full, q_empty, take, desc_push, desc_pop;

    assign in_stall = q_full;
    assign take = in_valid && !q_full;
    assign qctl.push = desc_push;
    assign qctl.pop = desc_pop;

    nsr_parse u_parse (
        .clk(clk), .rst_n(rst_n), .take(take), .in_data(in_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .desc_push(desc_push), .desc(push_desc)
    );

    nsr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .ctl(qctl), .wr_desc(push_desc),
        .rd_desc(head_desc), .full(q_full), .empty(q_empty)
    );

    nsr_reply u_reply (
        .clk(clk), .rst_n(rst_n), .head(head_desc), .empty(q_empty), .pop(desc_pop),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

### rtl/core/nsr_parse.sv
module nsr_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  nsr_pkg::in_t  in_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    output logic          desc_push,
    output nsr_pkg::desc_t desc
);

    logic [nsr_pkg::LEN_WIDTH-1:0] count_reg, count_next;
    logic [15:0] ether_reg, ether_next;
    logic [7:0]  proto_reg, proto_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [47:0] mac_reg, mac_next;
    logic [63:0] ip_hi_reg, ip_hi_next, ip_lo_reg, ip_lo_next;
    logic [63:0] tgt_hi_reg, tgt_hi_next, tgt_lo_reg, tgt_lo_next;
    logic [63:0] own_hi_reg, own_lo_reg;
    logic        check_en_reg;
    logic [7:0]  b;
    logic [nsr_pkg::LEN_WIDTH-1:0] pos;
    logic [1:0]  kind;

    assign b = in_data.frame_byte;
    assign pos = count_reg;

    always_comb
    begin
        count_next = count_reg;
        ether_next = ether_reg;
        proto_next = proto_reg;
        mtype_next = mtype_reg;
        mac_next = mac_reg;
        ip_hi_next = ip_hi_reg;
        ip_lo_next = ip_lo_reg;
        tgt_hi_next = tgt_hi_reg;
        tgt_lo_next = tgt_lo_reg;
        if (pos < nsr_pkg::LEN_MAX)
        begin
            if (pos >= 6 && pos <= 11)
                mac_next = {mac_reg[39:0], b};
            else if (pos == 12 || pos == 13)
                ether_next = {ether_reg[7:0], b};
            else if (pos == 20)
                proto_next = b;
            else if (pos >= 22 && pos < 30)
                ip_hi_next = {ip_hi_reg[55:0], b};
            else if (pos >= 30 && pos <= 37)
                ip_lo_next = {ip_lo_reg[55:0], b};
            else if (pos == 54)
                mtype_next = b;
            else if (pos >= 62 && pos < 70)
                tgt_hi_next = {tgt_hi_reg[55:0], b};
            else if (pos >= 70 && pos <= 77)
                tgt_lo_next = {tgt_lo_reg[55:0], b};
            count_next = pos + 1'b1;
        end
    end

    // classify on the captured values including this beat
    always_comb
    begin
        if (count_next < 14)
            kind = nsr_pkg::KIND_IGNORE;
        else if (ether_next == nsr_pkg::ETH_IPV4 || ether_next != nsr_pkg::ETH_IPV6)
            kind = nsr_pkg::KIND_PASS;
        else if (count_next < 54)
            kind = nsr_pkg::KIND_IGNORE;
        else if (proto_next != nsr_pkg::PROTO_ICMPV6 || count_next < 62)
            kind = nsr_pkg::KIND_PASS;
        else if (mtype_next != nsr_pkg::ICMP_NS)
            kind = nsr_pkg::KIND_PASS;
        else if (count_next < 78)
            kind = nsr_pkg::KIND_IGNORE;
        else if (check_en_reg && tgt_hi_next == own_hi_reg && tgt_lo_next == own_lo_reg)
            kind = nsr_pkg::KIND_IGNORE;
        else
            kind = nsr_pkg::KIND_ADV;
    end

    assign desc_push = take && in_data.frame_end;

    always_comb
    begin
        desc.kind = kind;
        desc.length = (kind == nsr_pkg::KIND_IGNORE) ? 16'd0 : 16'(count_next);
        desc.mac = mac_next;
        desc.ip_hi = ip_hi_next;
        desc.ip_lo = ip_lo_next;
        desc.tgt_hi = tgt_hi_next;
        desc.tgt_lo = tgt_lo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ether_reg <= '0;
            proto_reg <= '0;
            mtype_reg <= '0;
            mac_reg <= '0;
            ip_hi_reg <= '0;
            ip_lo_reg <= '0;
            tgt_hi_reg <= '0;
            tgt_lo_reg <= '0;
        end
        else if (take)
        begin
            if (in_data.frame_end)
            begin
                count_reg <= '0;
                ether_reg <= '0;
                proto_reg <= '0;
                mtype_reg <= '0;
                mac_reg <= '0;
                ip_hi_reg <= '0;
                ip_lo_reg <= '0;
                tgt_hi_reg <= '0;
                tgt_lo_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                ether_reg <= ether_next;
                proto_reg <= proto_next;
                mtype_reg <= mtype_next;
                mac_reg <= mac_next;
                ip_hi_reg <= ip_hi_next;
                ip_lo_reg <= ip_lo_next;
                tgt_hi_reg <= tgt_hi_next;
                tgt_lo_reg <= tgt_lo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_hi_reg <= '0;
            own_lo_reg <= '0;
            check_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nsr_pkg::REG_ADDR_HIGH: own_hi_reg <= cfg_data;
                nsr_pkg::REG_ADDR_LOW:  own_lo_reg <= cfg_data;
                nsr_pkg::REG_CHECK_EN:  check_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/nsr_queue.sv
module nsr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  nsr_pkg::qctl_t ctl,
    input  nsr_pkg::desc_t wr_desc,
    output nsr_pkg::desc_t rd_desc,
    output logic           full,
    output logic           empty
);

    nsr_pkg::desc_t slots [nsr_pkg::QUEUE_DEPTH];
    logic [nsr_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [nsr_pkg::QPTR_W:0]   fill_reg, fill_next;

    assign full = (fill_reg == (nsr_pkg::QPTR_W+1)'(nsr_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign rd_desc = slots[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.push && !ctl.pop)
            fill_next = fill_reg + 1'b1;
        else if (ctl.pop && !ctl.push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (ctl.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (ctl.pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            slots[wr_ptr_reg] <= wr_desc;
    end

endmodule

### rtl/core/nsr_reply.sv
module nsr_reply (
    input  logic           clk,
    input  logic           rst_n,
    input  nsr_pkg::desc_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output nsr_pkg::out_t  out_data
);

    nsr_pkg::desc_t cur_reg;
    logic busy_reg;
    logic [nsr_pkg::WCNT_W-1:0] cnt_reg;
    logic out_valid_reg;
    nsr_pkg::out_t out_reg;
    logic load_ok;

    logic unspec;
    logic [47:0] dst_mac, link_addr;
    logic [63:0] dst_hi, dst_lo;
    logic [7:0]  flags;
    logic [18:0] tsum_reg, isum_reg, xsum_reg;
    logic [21:0] total_reg;
    logic [15:0] cks_reg;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [0:nsr_pkg::WORD_COUNT-1][63:0] words;

    assign unspec = (cur_reg.ip_hi == '0) && (cur_reg.ip_lo == '0);
    assign dst_mac = unspec ? 48'h3333_0000_0001 : cur_reg.mac;
    assign dst_hi = unspec ? 64'hff02_0000_0000_0000 : cur_reg.ip_hi;
    assign dst_lo = unspec ? 64'h0000_0000_0000_0001 : cur_reg.ip_lo;
    assign link_addr = {16'h0200, cur_reg.tgt_lo[31:0]};
    // router flag always set; override always, solicited unless unspecified source
    assign flags = unspec ? 8'ha0 : 8'he0;

    // checksum runs in three stages, done well before the word that carries it
    always_ff @(posedge clk)
    begin
        tsum_reg <= 19'(cur_reg.tgt_hi[63:48]) + 19'(cur_reg.tgt_hi[47:32])
                  + 19'(cur_reg.tgt_hi[31:16]) + 19'(cur_reg.tgt_hi[15:0])
                  + 19'(cur_reg.tgt_lo[63:48]) + 19'(cur_reg.tgt_lo[47:32])
                  + 19'(cur_reg.tgt_lo[31:16]) + 19'(cur_reg.tgt_lo[15:0]);
        isum_reg <= 19'(dst_hi[63:48]) + 19'(dst_hi[47:32])
                  + 19'(dst_hi[31:16]) + 19'(dst_hi[15:0])
                  + 19'(dst_lo[63:48]) + 19'(dst_lo[47:32])
                  + 19'(dst_lo[31:16]) + 19'(dst_lo[15:0]);
        // pseudo header length and next header, type, flags, option header, link address
        xsum_reg <= 19'(16'd90) + 19'({nsr_pkg::ICMP_NA, 8'h00}) + 19'({flags, 8'h00})
                  + 19'(16'h0201) + 19'(16'h0200)
                  + 19'(cur_reg.tgt_lo[31:16]) + 19'(cur_reg.tgt_lo[15:0]);
        total_reg <= {tsum_reg, 1'b0} + 22'(isum_reg) + 22'(xsum_reg);
        cks_reg <= (~fold2 == 16'h0000) ? 16'hffff : ~fold2;
    end

    assign fold1 = 17'(total_reg[15:0]) + 17'(total_reg[21:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    assign words = {dst_mac, link_addr, nsr_pkg::ETH_IPV6, 8'h60, 24'h0, 16'd32,
                    nsr_pkg::PROTO_ICMPV6, 8'hff, cur_reg.tgt_hi, cur_reg.tgt_lo,
                    dst_hi, dst_lo, nsr_pkg::ICMP_NA, 8'h00, cks_reg, flags, 24'h0,
                    cur_reg.tgt_hi, cur_reg.tgt_lo, 8'h02, 8'h01, link_addr, 16'h0};

    assign load_ok = !out_valid_reg || !out_stall;
    assign pop = !busy_reg && !empty && (head.kind == nsr_pkg::KIND_ADV || load_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg)
            begin
                if (load_ok)
                begin
                    out_valid_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == nsr_pkg::WCNT_W'(nsr_pkg::WORD_COUNT - 1))
                        busy_reg <= 1'b0;
                end
            end
            else if (pop && head.kind == nsr_pkg::KIND_ADV)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
                if (load_ok)
                    out_valid_reg <= 1'b0;
            end
            else if (load_ok)
                out_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == nsr_pkg::KIND_ADV)
            cur_reg <= head;
        if (busy_reg && load_ok)
        begin
            out_reg.frame_kind <= nsr_pkg::KIND_ADV;
            out_reg.pass_length <= nsr_pkg::ADV_LENGTH;
            if (cnt_reg == nsr_pkg::WCNT_W'(nsr_pkg::WORD_COUNT - 1))
            begin
                out_reg.reply_word <= {words[cnt_reg][63:16], 16'h0};
                out_reg.reply_bytes <= 4'd6;
                out_reg.run_last <= 1'b1;
            end
            else
            begin
                out_reg.reply_word <= words[cnt_reg];
                out_reg.reply_bytes <= 4'd8;
                out_reg.run_last <= 1'b0;
            end
        end
        else if (!busy_reg && pop && head.kind != nsr_pkg::KIND_ADV)
        begin
            out_reg.frame_kind <= head.kind;
            out_reg.pass_length <= head.length;
            out_reg.reply_word <= '0;
            out_reg.reply_bytes <= 4'd0;
            out_reg.run_last <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

### rtl/core/nsr_checker.sv
`include "ipv6_neighbor_solicit_responder_assert.svh"

module nsr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input nsr_pkg::out_t out_data
);

    `NSR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output beat dropped while stalled")
    `NSR_ASSERT(a_mid_word, out_valid && out_data.frame_kind == nsr_pkg::KIND_ADV && !out_data.run_last |-> out_data.reply_bytes == 4'd8, "advertisement word not full")
    `NSR_ASSERT(a_last_word, out_valid && out_data.frame_kind == nsr_pkg::KIND_ADV && out_data.run_last |-> out_data.reply_bytes == 4'd6 && out_data.pass_length == nsr_pkg::ADV_LENGTH, "advertisement tail wrong")
    `NSR_ASSERT(a_single, out_valid && out_data.frame_kind != nsr_pkg::KIND_ADV |-> out_data.run_last && out_data.reply_bytes == 4'd0, "non-reply result not single beat")
    `NSR_ASSERT_ALWAYS(a_reset, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind ipv6_neighbor_solicit_responder nsr_checker u_nsr_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
);
